/* hdl/slte_pkg.sv */
// Package for the sorted list table engine.
// Holds the input and result word types and the mode and status codes.
// Depends on nothing.
package slte_pkg;

  localparam int VALUE_W = 32;
  localparam int SLOT_W = 6;
  localparam int MAX_DUMP = 63;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_COMPACT = 2'd2;
  localparam logic [1:0] MODE_DUMP = 2'd3;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_ENTRY = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [SLOT_W-1:0] slot;
    logic signed [VALUE_W-1:0] entry_value;
    logic last;
  } out_word_t;

endpackage

/* hdl/sorted_list_table_engine.sv */
// Top level of the sorted list table engine.
// Holds the value, link and remap memories and the sequencer that walks them.
// Depends on slte_pkg.

// A word is taken when start is high and busy is low; each result word appears for
// one cycle with out_valid high and the receiver cannot stall it, the last result of
// a command carries last. Each command walks the memories step by step: insert scans
// for the lowest free slot from slot 1 up, compares the new value with each entry of
// the list in turn until it finds a larger one or the end, and then links the new entry;
// delete visits each entry until one matches or the list ends; compact ranks the used
// slots, moves each used slot down to its rank, and then finishes; dump reads and
// shows one result word per list entry, at most 63 words.
module sorted_list_table_engine
  import slte_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = $clog2(SLOTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INS_SCAN = 4'd1;
  localparam logic [3:0] S_INS_WALK = 4'd2;
  localparam logic [3:0] S_INS_CHK = 4'd3;
  localparam logic [3:0] S_INS_LINK = 4'd4;
  localparam logic [3:0] S_INS_FIX = 4'd5;
  localparam logic [3:0] S_DEL_WALK = 4'd6;
  localparam logic [3:0] S_DEL_CHK = 4'd7;
  localparam logic [3:0] S_CMP_RANK = 4'd8;
  localparam logic [3:0] S_CMP_SCAN = 4'd9;
  localparam logic [3:0] S_CMP_MAP = 4'd10;
  localparam logic [3:0] S_CMP_WR = 4'd11;
  localparam logic [3:0] S_CMP_HEAD = 4'd12;
  localparam logic [3:0] S_CMP_DONE = 4'd13;
  localparam logic [3:0] S_DMP_RD = 4'd14;
  localparam logic [3:0] S_DMP_OUT = 4'd15;

  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [AW-1:0] NIL = '0;
  localparam logic [SLOT_W-1:0] DUMP_END = SLOT_W'(MAX_DUMP - 1);

  logic [VALUE_W-1:0] value_mem [SLOTS];
  logic [AW-1:0] link_mem [SLOTS];
  logic [AW-1:0] remap_mem [SLOTS];

  logic [3:0] state_r, state_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] free_r, free_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] rank_r, rank_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [VALUE_W-1:0] hold_r, hold_nxt;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  logic [AW-1:0] vl_ra, remap_ra;
  logic [VALUE_W-1:0] value_q;
  logic [AW-1:0] link_q, remap_q;
  logic value_we, link_we, remap_we;
  logic [AW-1:0] value_wa, link_wa, remap_wa;
  logic [VALUE_W-1:0] value_wd;
  logic [AW-1:0] link_wd, remap_wd;
  logic dump_last;

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_wa] <= value_wd;
    end
    value_q <= value_mem[vl_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[vl_ra];
  end

  always_ff @(posedge clk) begin
    if (remap_we) begin
      remap_mem[remap_wa] <= remap_wd;
    end
    remap_q <= remap_mem[remap_ra];
  end

  assign dump_last = (link_q == NIL) || (cnt_r == DUMP_END);

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    head_nxt = head_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    free_nxt = free_r;
    idx_nxt = idx_r;
    rank_nxt = rank_r;
    cnt_nxt = cnt_r;
    val_nxt = val_r;
    hold_nxt = hold_r;
    out_valid_nxt = 1'b0;
    out_word_nxt = out_word_r;
    vl_ra = cur_r;
    remap_ra = head_r;
    value_we = 1'b0;
    value_wa = free_r;
    value_wd = val_r;
    link_we = 1'b0;
    link_wa = free_r;
    link_wd = cur_r;
    remap_we = 1'b0;
    remap_wa = idx_r;
    remap_wd = NIL;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt = in_word.value;
          cur_nxt = head_r;
          prev_nxt = NIL;
          idx_nxt = NIL;
          rank_nxt = NIL;
          cnt_nxt = '0;
          unique case (in_word.mode)
            MODE_INSERT: begin
              idx_nxt = AW'(1);
              state_nxt = S_INS_SCAN;
            end
            MODE_DELETE: state_nxt = S_DEL_WALK;
            MODE_COMPACT: state_nxt = S_CMP_RANK;
            MODE_DUMP: begin
              if (head_r == NIL) begin
                out_valid_nxt = 1'b1;
                out_word_nxt = '{ST_EMPTY, '0, '0, 1'b1};
              end else begin
                state_nxt = S_DMP_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (!used_r[idx_r]) begin
          free_nxt = idx_r;
          state_nxt = S_INS_WALK;
        end else if (idx_r == LAST_SLOT) begin
          out_valid_nxt = 1'b1;
          out_word_nxt = '{ST_FULL, '0, val_r, 1'b1};
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_INS_WALK: begin
        state_nxt = (cur_r == NIL) ? S_INS_LINK : S_INS_CHK;
      end
      S_INS_CHK: begin
        if ($signed(value_q) <= val_r) begin
          prev_nxt = cur_r;
          cur_nxt = link_q;
          state_nxt = S_INS_WALK;
        end else begin
          state_nxt = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        value_we = 1'b1;
        link_we = 1'b1;
        used_nxt[free_r] = 1'b1;
        state_nxt = S_INS_FIX;
      end
      S_INS_FIX: begin
        if (prev_r == NIL) begin
          head_nxt = free_r;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r;
          link_wd = free_r;
        end
        out_valid_nxt = 1'b1;
        out_word_nxt = '{ST_DONE, SLOT_W'(free_r), val_r, 1'b1};
        state_nxt = S_IDLE;
      end
      S_DEL_WALK: begin
        if (cur_r == NIL) begin
          out_valid_nxt = 1'b1;
          out_word_nxt = '{ST_NOT_FOUND, '0, val_r, 1'b1};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DEL_CHK;
        end
      end
      S_DEL_CHK: begin
        if ($signed(value_q) == val_r) begin
          if (prev_r == NIL) begin
            head_nxt = link_q;
          end else begin
            link_we = 1'b1;
            link_wa = prev_r;
            link_wd = link_q;
          end
          used_nxt[cur_r] = 1'b0;
          out_valid_nxt = 1'b1;
          out_word_nxt = '{ST_DONE, SLOT_W'(cur_r), val_r, 1'b1};
          state_nxt = S_IDLE;
        end else begin
          prev_nxt = cur_r;
          cur_nxt = link_q;
          state_nxt = S_DEL_WALK;
        end
      end
      S_CMP_RANK: begin
        remap_we = 1'b1;
        if (used_r[idx_r] && (idx_r != NIL)) begin
          remap_wd = rank_r + AW'(1);
          rank_nxt = rank_r + AW'(1);
        end
        if (idx_r == LAST_SLOT) begin
          idx_nxt = AW'(1);
          cur_nxt = NIL;
          state_nxt = S_CMP_SCAN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_CMP_SCAN: begin
        vl_ra = idx_r;
        if (used_r[idx_r]) begin
          state_nxt = S_CMP_MAP;
        end else if (idx_r == LAST_SLOT) begin
          state_nxt = S_CMP_HEAD;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_CMP_MAP: begin
        remap_ra = link_q;
        hold_nxt = value_q;
        cur_nxt = cur_r + AW'(1);
        state_nxt = S_CMP_WR;
      end
      S_CMP_WR: begin
        value_we = 1'b1;
        value_wa = cur_r;
        value_wd = hold_r;
        link_we = 1'b1;
        link_wa = cur_r;
        link_wd = remap_q;
        if (idx_r == LAST_SLOT) begin
          state_nxt = S_CMP_HEAD;
        end else begin
          idx_nxt = idx_r + AW'(1);
          state_nxt = S_CMP_SCAN;
        end
      end
      S_CMP_HEAD: begin
        remap_ra = head_r;
        state_nxt = S_CMP_DONE;
      end
      S_CMP_DONE: begin
        head_nxt = remap_q;
        for (int j = 0; j < SLOTS; j++) begin
          used_nxt[j] = (j != 0) && (AW'(j) <= rank_r);
        end
        out_valid_nxt = 1'b1;
        out_word_nxt = '{ST_DONE, '0, '0, 1'b1};
        state_nxt = S_IDLE;
      end
      S_DMP_RD: begin
        state_nxt = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        out_valid_nxt = 1'b1;
        out_word_nxt = '{ST_ENTRY, SLOT_W'(cur_r), $signed(value_q), dump_last};
        if (dump_last) begin
          state_nxt = S_IDLE;
        end else begin
          cur_nxt = link_q;
          cnt_nxt = cnt_r + SLOT_W'(1);
          state_nxt = S_DMP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      head_r <= NIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      head_r <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    free_r <= free_nxt;
    idx_r <= idx_nxt;
    rank_r <= rank_nxt;
    cnt_r <= cnt_nxt;
    val_r <= val_nxt;
    hold_r <= hold_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

endmodule

/* hdl/slte_checker.sv */
// Port-level checker for the sorted list table engine, bound to its top level.
// Depends on slte_pkg and sorted_list_table_engine.
module slte_checker
  import slte_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("Accepted word made neither progress nor a result.");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |-> busy)
    else $error("A non-final result word was shown while idle.");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == ST_EMPTY)) |->
      ((out_word.slot == '0) && (out_word.entry_value == '0) && out_word.last))
    else $error("Empty list word carries data.");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_word.status == ST_FULL) || (out_word.status == ST_NOT_FOUND)))
      |-> ((out_word.slot == '0) && out_word.last))
    else $error("Failed command word names a slot.");

endmodule

bind sorted_list_table_engine slte_checker u_slte_checker (.*);
